// ===== sv/sle_pkg.sv =====
// Package for the sorted list engine: sizes, command and status codes,
// and the controller-to-datapath command struct.
// No dependencies.
package sle_pkg;

    // Store size and derived widths
    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int POS_W     = (CNT_W > 4) ? CNT_W : 4;
    localparam int REP_W     = (CNT_W > 5) ? CNT_W : 5;
    localparam int DATA_W    = 32;

    // Command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the request fields
        logic exec;   // update the cell row, count and result registers
    } ctl_t;

endpackage

// ===== sv/sle_ctrl.sv =====
// Controller for the sorted list engine: accepts a request and sequences
// the datapath through its execute state. Depends on sle_pkg.
module sle_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output sle_pkg::ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == S_EXEC);
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign ctl.load = accept;
    assign ctl.exec = (state_reg == S_EXEC);

    // An accepted request always executes in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctl.exec)
        else $error("accepted request did not execute");

    // The result strobe follows the execute cycle exactly
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(ctl.exec) && !busy_reg)
        else $error("result strobe without execute cycle");

endmodule

// ===== sv/sle_datapath.sv =====
// Datapath for the sorted list engine: request registers, the row of
// ordered value cells with compare/shift logic, and result registers.
// Depends on sle_pkg.
module sle_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sle_pkg::ctl_t                 ctl,
    input  logic [1:0]                    command,
    input  logic signed [sle_pkg::DATA_W-1:0] value,
    input  logic [3:0]                    position,
    output logic signed [sle_pkg::DATA_W-1:0] read_value,
    output logic [1:0]                    status,
    output logic [4:0]                    entry_count,
    output logic                          is_empty
);

    sle_pkg::cmd_t                         req_cmd_reg;
    logic signed [sle_pkg::DATA_W-1:0]     req_value_reg;
    logic [sle_pkg::POS_W-1:0]             req_pos_reg;

    logic signed [sle_pkg::DATA_W-1:0]     cells_reg  [sle_pkg::CAPACITY];
    logic signed [sle_pkg::DATA_W-1:0]     cells_next [sle_pkg::CAPACITY];
    logic [sle_pkg::CNT_W-1:0]             count_reg;
    logic [sle_pkg::CNT_W-1:0]             count_next;
    logic signed [sle_pkg::DATA_W-1:0]     read_value_reg;
    logic signed [sle_pkg::DATA_W-1:0]     read_value_next;
    logic [1:0]                            status_reg;
    logic [1:0]                            status_next;

    logic [sle_pkg::CAPACITY-1:0]          at_or_past_slot;
    logic [sle_pkg::POS_W-1:0]             count_ext;
    logic                                  pos_ok;
    logic                                  full;
    logic [sle_pkg::IDX_W-1:0]             rd_idx;
    logic [sle_pkg::REP_W-1:0]             count_rep;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_cmd_reg   <= sle_pkg::cmd_t'(command);
            req_value_reg <= value;
            req_pos_reg   <= sle_pkg::POS_W'(position);
        end
    end

    assign count_ext = sle_pkg::POS_W'(count_reg);
    assign pos_ok    = (req_pos_reg < count_ext);
    assign full      = (count_reg >= sle_pkg::CNT_W'(sle_pkg::CAPACITY));
    assign rd_idx    = req_pos_reg[sle_pkg::IDX_W-1:0];

    // Per-cell compare: cell lies at or after the insertion slot
    always_comb
    begin
        for (int i = 0; i < sle_pkg::CAPACITY; i++)
        begin
            at_or_past_slot[i] = (sle_pkg::POS_W'(i) >= count_ext) ||
                                 (cells_reg[i] > req_value_reg);
        end
    end

    // Next cell row, count and result
    always_comb
    begin
        for (int i = 0; i < sle_pkg::CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
        end
        count_next      = count_reg;
        read_value_next = '0;
        status_next     = sle_pkg::ST_OK;

        case (req_cmd_reg)
            sle_pkg::CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = sle_pkg::ST_FULL;
                end
                else
                begin
                    // first cell at the slot takes the value, later ones shift up
                    for (int i = 0; i < sle_pkg::CAPACITY; i++)
                    begin
                        if (at_or_past_slot[i])
                        begin
                            if (i == 0)
                            begin
                                cells_next[i] = req_value_reg;
                            end
                            else if (!at_or_past_slot[i-1])
                            begin
                                cells_next[i] = req_value_reg;
                            end
                            else
                            begin
                                cells_next[i] = cells_reg[i-1];
                            end
                        end
                    end
                    count_next = count_reg + sle_pkg::CNT_W'(1);
                end
            end
            sle_pkg::CMD_READ:
            begin
                if (pos_ok)
                begin
                    read_value_next = cells_reg[rd_idx];
                end
                else
                begin
                    status_next = sle_pkg::ST_RANGE;
                end
            end
            sle_pkg::CMD_REMOVE:
            begin
                if (pos_ok)
                begin
                    // cells from the index on pull from their upper neighbor
                    for (int i = 0; i < sle_pkg::CAPACITY - 1; i++)
                    begin
                        if (sle_pkg::POS_W'(i) >= req_pos_reg)
                        begin
                            cells_next[i] = cells_reg[i+1];
                        end
                    end
                    count_next = count_reg - sle_pkg::CNT_W'(1);
                end
                else
                begin
                    status_next = sle_pkg::ST_RANGE;
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // Cell row (undefined until written)
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            for (int i = 0; i < sle_pkg::CAPACITY; i++)
            begin
                cells_reg[i] <= cells_next[i];
            end
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign count_rep   = sle_pkg::REP_W'(count_reg);
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = count_rep[4:0];
    assign is_empty    = (count_reg == '0);

    // Count never exceeds the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sle_pkg::CNT_W'(sle_pkg::CAPACITY))
        else $error("entry count above capacity");

    // Count changes only in an execute cycle
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.exec |=> $stable(count_reg))
        else $error("entry count changed outside execute");

    // A range or full error leaves the count unchanged
    a_range_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec && (status_next == sle_pkg::ST_RANGE || status_next == sle_pkg::ST_FULL)
        |=> $stable(count_reg))
        else $error("failed request changed the count");

endmodule

// ===== sv/sorted_list_engine_unit.sv =====
// Sorted list engine: up to CAPACITY signed values kept in ascending order.
// The execute cycle follows the edge that accepts start; done is high in the
// cycle after the execute cycle, and the result is taken at the edge ending it.
// Start is not accepted while busy is high; busy is high for the execute
// cycle in which the whole cell row compares and shifts at once.
// Reset (rst_n low, asynchronous) empties the store; results are shown for
// one cycle under done and cannot be stalled.
module sorted_list_engine_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic signed [sle_pkg::DATA_W-1:0] value,
    input  logic [3:0]                        position,
    output logic                              done,
    output logic signed [sle_pkg::DATA_W-1:0] read_value,
    output logic [1:0]                        status,
    output logic [4:0]                        entry_count,
    output logic                              is_empty
);

    sle_pkg::ctl_t ctl;

    sle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    sle_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .command     (command),
        .value       (value),
        .position    (position),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

endmodule
